/* hw/rtl/csv_pkg.sv */
// Package for the callsign/SSID validator: item types, state type, limits
// and the character class helpers. No dependencies.
`default_nettype none

package csv_pkg;

    localparam int MAX_PREFIX_CHARS = 6;
    localparam int COUNT_SAT = (MAX_PREFIX_CHARS + 1 > 3) ? (MAX_PREFIX_CHARS + 1) : 3;
    localparam int CNT_W = $clog2(COUNT_SAT + 1);

    localparam logic [7:0] CH_HYPHEN = 8'h2D;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_UC_A   = 8'h41;
    localparam logic [7:0] CH_UC_Z   = 8'h5A;
    localparam logic [7:0] CH_LC_A   = 8'h61;
    localparam logic [7:0] CH_LC_Z   = 8'h7A;
    localparam logic [7:0] CASE_DIFF = 8'h20;
    localparam logic [7:0] SSID_MAX  = 8'd15;
    localparam logic [7:0] SSID_RADIX = 8'd10;
    localparam logic [CNT_W-1:0] CNT_SAT_V   = CNT_W'(COUNT_SAT);
    localparam logic [CNT_W-1:0] CNT_PREFIX  = CNT_W'(MAX_PREFIX_CHARS);
    localparam logic [CNT_W-1:0] CNT_DROP_MIN = CNT_W'(3);

    typedef struct packed {
        logic [7:0] ch_in;
        logic       strict_mode;
        logic       is_last;
    } t_in_item;

    typedef struct packed {
        logic [7:0] ch_out;
        logic       done_res;
        logic       valid_res;
        logic       drop_ssid_zero;
    } t_out_item;

    typedef struct packed {
        logic [CNT_W-1:0] char_count;
        logic             hyphen_seen;
        logic [3:0]       ssid_value;
        logic             failed_flag;
        logic             prev_was_hyphen;
    } t_state;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic is_alnum_upper(input logic [7:0] c);
        return ((c >= CH_UC_A) && (c <= CH_UC_Z)) || is_digit(c);
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/csv_in_if.sv */
// Input channel for the validator: valid/ready handshake and one character request.
// Depends on csv_pkg.
`default_nettype none

interface csv_in_if import csv_pkg::*;;
    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* hw/rtl/csv_out_if.sv */
// Output channel for the validator: valid/ready handshake and one result request.
// Depends on csv_pkg.
`default_nettype none

interface csv_out_if import csv_pkg::*;;
    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* hw/rtl/callsign_ssid_validator.sv */
// Callsign/SSID validator top level: input register, rule check, result register.
// A request is held in the input register, checked, and moved into the result register once the output is free.
// Throughput: one character per cycle, limited only by the output ready.
// Reset (synchronous, active low) empties both registers and clears the
// per-string state. Depends on csv_pkg, csv_in_if, csv_out_if, csv_check.
`default_nettype none

module callsign_ssid_validator import csv_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    csv_in_if.sink    i_in,
    csv_out_if.source o_out
);

    logic      r_in_valid;
    t_in_item  r_in_item;
    logic      r_out_valid;
    t_out_item r_out_item;
    logic      w_advance;
    t_out_item w_result;

    assign w_advance   = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready  = !r_in_valid || w_advance;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out_item;

    csv_check u_check (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (w_advance),
        .i_item    (r_in_item),
        .o_result  (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            if (w_advance) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (i_in.ready && i_in.valid) begin
            r_in_item <= i_in.data;
        end
        if (w_advance) begin
            r_out_item <= w_result;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/csv_check.sv */
// Per-character rule check and per-string state for the validator.
// Depends on csv_pkg.
`default_nettype none

module csv_check import csv_pkg::*; (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_advance,
    input  wire t_in_item  i_item,
    output t_out_item      o_result
);

    t_state r_state;
    t_state n_state;

    logic [7:0] w_up;
    logic [7:0] w_ssid_sum;
    logic       w_fail;
    logic       w_was_hyphen;
    logic       w_failed_next;
    logic       w_valid;

    always_comb begin
        w_up = i_item.ch_in;
        if ((i_item.ch_in >= CH_LC_A) && (i_item.ch_in <= CH_LC_Z)) begin
            w_up = i_item.ch_in - CASE_DIFF;
        end
    end

    assign w_ssid_sum = ({4'd0, r_state.ssid_value} * SSID_RADIX) + (w_up - CH_ZERO);

    always_comb begin
        w_fail       = 1'b0;
        w_was_hyphen = 1'b0;
        n_state      = r_state;
        if (!r_state.failed_flag) begin
            if (w_up == CH_HYPHEN) begin
                if (r_state.hyphen_seen || (r_state.char_count == '0) || i_item.is_last
                        || (r_state.char_count > CNT_PREFIX)) begin
                    w_fail = 1'b1;
                end else begin
                    n_state.hyphen_seen = 1'b1;
                    w_was_hyphen        = 1'b1;
                end
            end else if (!r_state.hyphen_seen || !i_item.strict_mode) begin
                w_fail = !is_alnum_upper(w_up);
            end else if (is_digit(w_up)) begin
                if (w_ssid_sum > SSID_MAX) begin
                    w_fail = 1'b1;
                end else begin
                    n_state.ssid_value = w_ssid_sum[3:0];
                end
            end else begin
                w_fail = 1'b1;
            end
        end
        w_failed_next       = r_state.failed_flag | w_fail;
        n_state.failed_flag = w_failed_next;
        if (i_item.is_last) begin
            n_state = '0;
        end else begin
            if (r_state.char_count < CNT_SAT_V) begin
                n_state.char_count = r_state.char_count + 1'b1;
            end
            n_state.prev_was_hyphen = w_was_hyphen;
        end
    end

    assign w_valid = i_item.is_last && !w_failed_next;

    always_comb begin
        o_result.ch_out         = r_state.failed_flag ? i_item.ch_in : w_up;
        o_result.done_res       = i_item.is_last;
        o_result.valid_res      = w_valid;
        o_result.drop_ssid_zero = w_valid && (r_state.char_count >= CNT_DROP_MIN)
                                  && (w_up == CH_ZERO) && r_state.prev_was_hyphen;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (i_advance) begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire
